// File: src/dsfc_pkg.sv
// ----------------------------------------------------------------------------
// dsfc_pkg
// shared types, codes and helpers of the smoothstep fade dimmer
// ----------------------------------------------------------------------------
`default_nettype none

package dsfc_pkg;

  localparam int unsigned StepW  = 13;
  localparam int unsigned LevelW = 8;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned FracW  = 16;
  localparam int unsigned DivW   = StepW + FracW;   // step * frac_one
  localparam int unsigned ProdW  = 34;              // widest product
  localparam int unsigned EstW   = ProdW - FracW + 1;

  localparam logic [FracW-1:0]  FracOne    = 16'hFFFF;
  localparam logic [17:0]       FracThree  = 18'd196605;
  localparam logic [LevelW-1:0] LevelMax   = 8'd254;

  // command codes
  localparam logic [2:0] OP_SET_ON    = 3'd0;
  localparam logic [2:0] OP_SET_LEVEL = 3'd1;
  localparam logic [2:0] OP_CLUSTER   = 3'd2;
  localparam logic [2:0] OP_TICK      = 3'd3;
  localparam logic [2:0] OP_SYNC      = 3'd4;
  localparam logic [2:0] OP_FAULT_OFF = 3'd5;
  localparam logic [2:0] OP_RECOVER   = 3'd6;

  // register indexes
  localparam logic [1:0] REG_STEPS_ON    = 2'd0;
  localparam logic [1:0] REG_STEPS_OFF   = 2'd1;
  localparam logic [1:0] REG_STEPS_LEVEL = 2'd2;

  // multiply passes of the curve evaluation
  localparam logic [1:0] PASS_SQUARE = 2'd0;
  localparam logic [1:0] PASS_CUBE   = 2'd1;
  localparam logic [1:0] PASS_SCALE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_MUL,
    ST_EST,
    ST_FIX,
    ST_APPLY
  } ctrl_state_e;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       mul;
    logic       est;
    logic       fix;
    logic [1:0] pass;
    logic       apply;
  } dp_cmd_t;

  typedef struct packed {
    logic need_interp;
    logic div_done;
  } dp_stat_t;

  // level * 100 / 254 through a reciprocal, exact for 8-bit levels
  function automatic logic [DutyW-1:0] level_pct(input logic [LevelW-1:0] lv);
    logic [28:0] prod;
    prod = {21'd0, lv} * 29'd1651301;
    return prod[28:22];
  endfunction

endpackage

`default_nettype wire

// File: src/dimmer_smoothstep_fade_controller_core.sv
// ----------------------------------------------------------------------------
// dimmer_smoothstep_fade_controller_core
// lamp dimmer with smoothstep fades, fault kill and pre-fault save/restore
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ---------------------------------
//  in        sink       in_valid_i / in_stall_o  op, on_request, level_value,
//                                               fault_active, blocks_turn_on
//  out       source     out_valid_o/out_stall_i  duty, enables, lamp and saved state
//  cfg       sink       cfg_we_i (no wait)       cfg_idx_i, cfg_data_i
//
//  one word at a time; most commands pass intake, decide and handoff in turn
//  a tick inside a fade also waits on the bit-serial divider
//  (29 quotient bits of step * one / total) and three multiply / estimate / fix passes
//  the output register lets the block take the next word while a result waits
//  a stalled result holds the sequencer in its last step until taken
//  reset puts the lamp off at level 254 with the step counts 45, 35, 30
//
`default_nettype none

module dimmer_smoothstep_fade_controller_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [dsfc_pkg::StepW-1:0]  cfg_data_i,
  // command word
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [2:0]                  op_i,
  input  wire logic                        on_request_i,
  input  wire logic [dsfc_pkg::LevelW-1:0] level_value_i,
  input  wire logic                        fault_active_i,
  input  wire logic                        blocks_turn_on_i,
  // result word
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [dsfc_pkg::DutyW-1:0]       duty_percent_o,
  output logic                             output_enabled_o,
  output logic                             fading_o,
  output logic                             lamp_on_o,
  output logic [dsfc_pkg::LevelW-1:0]      lamp_level_o,
  output logic                             command_accepted_o,
  output logic                             saved_valid_o,
  output logic                             saved_on_o,
  output logic [dsfc_pkg::LevelW-1:0]      saved_level_o
);

  // sequencer to datapath
  dsfc_pkg::dp_cmd_t  cmd;
  dsfc_pkg::dp_stat_t stat;

  // controller: intake, curve steps, handoff to the output register
  dsfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: lamp state, fade arithmetic, step registers, result word
  dsfc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .op_i               (op_i),
    .on_request_i       (on_request_i),
    .level_value_i      (level_value_i),
    .fault_active_i     (fault_active_i),
    .blocks_turn_on_i   (blocks_turn_on_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .duty_percent_o     (duty_percent_o),
    .output_enabled_o   (output_enabled_o),
    .fading_o           (fading_o),
    .lamp_on_o          (lamp_on_o),
    .lamp_level_o       (lamp_level_o),
    .command_accepted_o (command_accepted_o),
    .saved_valid_o      (saved_valid_o),
    .saved_on_o         (saved_on_o),
    .saved_level_o      (saved_level_o)
  );

endmodule

`default_nettype wire

// File: src/dsfc_div.sv
// ----------------------------------------------------------------------------
// dsfc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dsfc_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [dsfc_pkg::DivW-1:0]    dividend_i,
  input  wire logic [dsfc_pkg::StepW-1:0]   divisor_i,
  output logic                              done_o,
  output logic [dsfc_pkg::FracW-1:0]        quotient_o
);

  logic                           run_q, run_d;
  logic                           done_q, done_d;
  logic [4:0]                     cnt_q, cnt_d;
  logic [dsfc_pkg::StepW-1:0]     rem_q, rem_d;
  logic [dsfc_pkg::DivW-1:0]      dq_q, dq_d;
  logic [dsfc_pkg::StepW:0]       rem_sh;
  logic                           ge;

  always_comb begin
    rem_sh = {rem_q, dq_q[dsfc_pkg::DivW-1]};
    ge     = rem_sh >= {1'b0, divisor_i};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = 5'(dsfc_pkg::DivW - 1);
      rem_d = '0;
      dq_d  = dividend_i;
    end else if (run_q) begin
      rem_d = ge ? dsfc_pkg::StepW'(rem_sh - {1'b0, divisor_i})
                 : dsfc_pkg::StepW'(rem_sh);
      dq_d  = {dq_q[dsfc_pkg::DivW-2:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q[dsfc_pkg::FracW-1:0];

endmodule

`default_nettype wire

// File: src/dsfc_ctrl.sv
// ----------------------------------------------------------------------------
// dsfc_ctrl
// sequencer: command intake, curve evaluation steps, result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module dsfc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire dsfc_pkg::dp_stat_t stat_i,
  output dsfc_pkg::dp_cmd_t      cmd_o
);

  dsfc_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]            pass_q, pass_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    case (state_q)
      dsfc_pkg::ST_IDLE:   if (in_valid_i) state_d = dsfc_pkg::ST_DECIDE;
      dsfc_pkg::ST_DECIDE: begin
        pass_d  = dsfc_pkg::PASS_SQUARE;
        state_d = stat_i.need_interp ? dsfc_pkg::ST_DIV : dsfc_pkg::ST_APPLY;
      end
      dsfc_pkg::ST_DIV:    if (stat_i.div_done) state_d = dsfc_pkg::ST_MUL;
      dsfc_pkg::ST_MUL:    state_d = dsfc_pkg::ST_EST;
      dsfc_pkg::ST_EST:    state_d = dsfc_pkg::ST_FIX;
      dsfc_pkg::ST_FIX: begin
        if (pass_q == dsfc_pkg::PASS_SCALE) begin
          state_d = dsfc_pkg::ST_APPLY;
        end else begin
          pass_d  = pass_q + 2'd1;
          state_d = dsfc_pkg::ST_MUL;
        end
      end
      dsfc_pkg::ST_APPLY:  if (out_free) state_d = dsfc_pkg::ST_IDLE;
      default:             state_d = dsfc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.pass  = pass_q;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      dsfc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      dsfc_pkg::ST_DECIDE: cmd_o.div_start = stat_i.need_interp;
      dsfc_pkg::ST_MUL:    cmd_o.mul = 1'b1;
      dsfc_pkg::ST_EST:    cmd_o.est = 1'b1;
      dsfc_pkg::ST_FIX:    cmd_o.fix = 1'b1;
      dsfc_pkg::ST_APPLY: begin
        if (out_free) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsfc_pkg::ST_IDLE;
      pass_q      <= dsfc_pkg::PASS_SQUARE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: src/dsfc_dp.sv
// ----------------------------------------------------------------------------
// dsfc_dp
// lamp state, fade curve arithmetic, step registers and result word
// ----------------------------------------------------------------------------
`default_nettype none

module dsfc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [dsfc_pkg::StepW-1:0]    cfg_data_i,
  input  wire logic [2:0]                    op_i,
  input  wire logic                          on_request_i,
  input  wire logic [dsfc_pkg::LevelW-1:0]   level_value_i,
  input  wire logic                          fault_active_i,
  input  wire logic                          blocks_turn_on_i,
  input  wire dsfc_pkg::dp_cmd_t             cmd_i,
  output dsfc_pkg::dp_stat_t                 stat_o,
  output logic [dsfc_pkg::DutyW-1:0]         duty_percent_o,
  output logic                               output_enabled_o,
  output logic                               fading_o,
  output logic                               lamp_on_o,
  output logic [dsfc_pkg::LevelW-1:0]        lamp_level_o,
  output logic                               command_accepted_o,
  output logic                               saved_valid_o,
  output logic                               saved_on_o,
  output logic [dsfc_pkg::LevelW-1:0]        saved_level_o
);

  localparam int unsigned SW = dsfc_pkg::StepW;
  localparam int unsigned LW = dsfc_pkg::LevelW;
  localparam int unsigned DW = dsfc_pkg::DutyW;
  localparam int unsigned FW = dsfc_pkg::FracW;
  localparam int unsigned PW = dsfc_pkg::ProdW;
  localparam int unsigned EW = dsfc_pkg::EstW;

  // step registers
  logic [SW-1:0] steps_on_q, steps_off_q, steps_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_on_q  <= SW'(45);
      steps_off_q <= SW'(35);
      steps_lvl_q <= SW'(30);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsfc_pkg::REG_STEPS_ON:    steps_on_q  <= cfg_data_i;
        dsfc_pkg::REG_STEPS_OFF:   steps_off_q <= cfg_data_i;
        dsfc_pkg::REG_STEPS_LEVEL: steps_lvl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero counts run as one tick
  function automatic logic [SW-1:0] steps_of(input logic [SW-1:0] v);
    return (v == '0) ? SW'(1) : v;
  endfunction

  // latched word
  logic [2:0]    op_q;
  logic          req_q, fault_q, block_q;
  logic [LW-1:0] lv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      req_q   <= on_request_i;
      lv_q    <= level_value_i;
      fault_q <= fault_active_i;
      block_q <= blocks_turn_on_i;
    end
  end

  // lamp state
  logic          on_q, on_d, busy_q, busy_d, killed_q, killed_d;
  logic          hold_valid_q, hold_valid_d, hold_on_q, hold_on_d;
  logic [LW-1:0] level_q, level_d, hold_level_q, hold_level_d;
  logic [DW-1:0] shown_q, shown_d, start_q, start_d, target_q, target_d;
  logic [SW-1:0] cnt_q, cnt_d, total_q, total_d;

  logic [SW-1:0] step_next;
  assign step_next = cnt_q + SW'(1);

  assign stat_o.need_interp = (op_q == dsfc_pkg::OP_TICK) && busy_q && !fault_q
                              && (step_next < total_q);

  // curve: t = step * one / total
  logic          div_done;
  logic [FW-1:0] t_val;
  logic [dsfc_pkg::DivW-1:0] dividend;

  assign dividend = {step_next, {FW{1'b0}}} - {{FW{1'b0}}, step_next};

  dsfc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (t_val)
  );

  assign stat_o.div_done = div_done;

  // shared multiply, then divide by one through estimate and fix
  logic [PW-1:0] prod_q;
  logic [EW-1:0] est_q;
  logic [FW-1:0] quo_q;
  logic [17:0]   cube_fac;
  logic [DW-1:0] mag;
  logic          neg;
  logic [PW:0]   est_sum;
  logic [PW+1:0] rem_est;

  assign neg      = target_q < start_q;
  assign mag      = neg ? (start_q - target_q) : (target_q - start_q);
  assign cube_fac = dsfc_pkg::FracThree - {1'b0, t_val, 1'b0};
  assign est_sum  = {1'b0, prod_q} + {{(FW+1){1'b0}}, prod_q[PW-1:FW]};
  assign rem_est  = {2'b00, prod_q} + {{(PW+2-EW){1'b0}}, est_q}
                    - {1'b0, est_q, {FW{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      case (cmd_i.pass)
        dsfc_pkg::PASS_SQUARE: prod_q <= PW'({16'd0, t_val} * {16'd0, t_val});
        dsfc_pkg::PASS_CUBE:   prod_q <= PW'({18'd0, quo_q} * {16'd0, cube_fac});
        default:               prod_q <= PW'({9'd0, mag} * {7'd0, quo_q});
      endcase
    end
    if (cmd_i.est) est_q <= est_sum[PW:FW];
    if (cmd_i.fix) begin
      quo_q <= (rem_est >= {{(PW+2-FW){1'b0}}, dsfc_pkg::FracOne})
               ? FW'(est_q + EW'(1)) : FW'(est_q);
    end
  end

  logic [DW-1:0] frame;
  assign frame = neg ? (start_q - DW'(quo_q)) : (start_q + DW'(quo_q));

  // next lamp state for the latched word
  logic          accepted;
  logic          fade_go, fade_restart, fade_on;
  logic          pct_on;
  logic [LW-1:0] pct_lvl, lvl_eff;
  logic [DW-1:0] pct_val, tgt, st;

  always_comb begin
    on_d         = on_q;
    busy_d       = busy_q;
    killed_d     = killed_q;
    hold_valid_d = hold_valid_q;
    hold_on_d    = hold_on_q;
    level_d      = level_q;
    hold_level_d = hold_level_q;
    shown_d      = shown_q;
    start_d      = start_q;
    target_d     = target_q;
    cnt_d        = cnt_q;
    total_d      = total_q;
    accepted     = 1'b1;
    fade_go      = 1'b0;
    fade_restart = 1'b0;
    fade_on      = on_q;
    pct_on       = 1'b0;
    pct_lvl      = lv_q;
    lvl_eff      = (req_q && level_q <= LW'(1)) ? dsfc_pkg::LevelMax : level_q;

    // one shared level-to-duty conversion
    case (op_q)
      dsfc_pkg::OP_SET_ON: begin
        pct_on  = req_q;
        pct_lvl = lvl_eff;
      end
      dsfc_pkg::OP_RECOVER: begin
        pct_on  = hold_valid_q ? hold_on_q : on_q;
        pct_lvl = hold_valid_q ? hold_level_q : level_q;
      end
      dsfc_pkg::OP_SET_LEVEL, dsfc_pkg::OP_CLUSTER: pct_on = on_q;
      default: pct_on = req_q;
    endcase
    pct_val = pct_on ? dsfc_pkg::level_pct(pct_lvl) : '0;

    case (op_q)
      dsfc_pkg::OP_SET_ON: begin
        if (req_q && block_q) begin
          accepted = 1'b0;
        end else begin
          on_d         = req_q;
          level_d      = lvl_eff;
          fade_go      = 1'b1;
          fade_restart = 1'b1;
          fade_on      = req_q;
        end
      end
      dsfc_pkg::OP_SET_LEVEL, dsfc_pkg::OP_CLUSTER: begin
        if (!(op_q == dsfc_pkg::OP_CLUSTER && !on_q)) begin
          level_d = lv_q;
          fade_go = on_q;
        end
      end
      dsfc_pkg::OP_TICK: begin
        if (!busy_q || fault_q) begin
          busy_d = 1'b0;
        end else begin
          cnt_d    = step_next;
          killed_d = 1'b0;
          if (step_next >= total_q) begin
            busy_d  = 1'b0;
            shown_d = target_q;
          end else begin
            shown_d = frame;
          end
        end
      end
      dsfc_pkg::OP_SYNC: begin
        on_d    = req_q;
        level_d = lv_q;
        busy_d  = 1'b0;
        if (fault_q) begin
          killed_d = 1'b1;
        end else begin
          killed_d = 1'b0;
          shown_d  = pct_val;
        end
      end
      dsfc_pkg::OP_FAULT_OFF: begin
        if (!hold_valid_q) begin
          hold_on_d    = on_q;
          hold_level_d = level_q;
          hold_valid_d = 1'b1;
        end
        busy_d   = 1'b0;
        on_d     = 1'b0;
        shown_d  = '0;
        killed_d = 1'b1;
      end
      dsfc_pkg::OP_RECOVER: begin
        if (hold_valid_q) begin
          on_d         = hold_on_q;
          level_d      = hold_level_q;
          hold_valid_d = 1'b0;
        end
        busy_d = 1'b0;
        if (fault_q) begin
          killed_d = 1'b1;
        end else begin
          killed_d = 1'b0;
          shown_d  = pct_val;
        end
      end
      default: ;
    endcase

    // fade start
    tgt = pct_val;
    st  = (!busy_q || fade_restart) ? shown_q : start_q;
    if (fade_go) begin
      if (fault_q) begin
        busy_d   = 1'b0;
        killed_d = 1'b1;
      end else begin
        target_d = tgt;
        start_d  = st;
        killed_d = 1'b0;
        if (st == tgt) begin
          busy_d  = 1'b0;
          shown_d = tgt;
        end else begin
          cnt_d   = '0;
          total_d = !fade_on      ? steps_of(steps_off_q)
                  : fade_restart ? steps_of(steps_on_q)
                                 : steps_of(steps_lvl_q);
          shown_d = st;
          busy_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q         <= 1'b0;
      busy_q       <= 1'b0;
      killed_q     <= 1'b0;
      hold_valid_q <= 1'b0;
      hold_on_q    <= 1'b0;
      level_q      <= dsfc_pkg::LevelMax;
      hold_level_q <= dsfc_pkg::LevelMax;
      shown_q      <= '0;
      start_q      <= '0;
      target_q     <= '0;
      cnt_q        <= '0;
      total_q      <= '0;
    end else if (cmd_i.apply) begin
      on_q         <= on_d;
      busy_q       <= busy_d;
      killed_q     <= killed_d;
      hold_valid_q <= hold_valid_d;
      hold_on_q    <= hold_on_d;
      level_q      <= level_d;
      hold_level_q <= hold_level_d;
      shown_q      <= shown_d;
      start_q      <= start_d;
      target_q     <= target_d;
      cnt_q        <= cnt_d;
      total_q      <= total_d;
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      duty_percent_o     <= shown_d;
      output_enabled_o   <= !killed_d;
      fading_o           <= busy_d;
      lamp_on_o          <= on_d;
      lamp_level_o       <= level_d;
      command_accepted_o <= accepted;
      saved_valid_o      <= hold_valid_d;
      saved_on_o         <= hold_on_d;
      saved_level_o      <= hold_level_d;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/dimmer_smoothstep_fade_controller_core_tb.sv
// ----------------------------------------------------------------------------
// dimmer_smoothstep_fade_controller_core_tb
// self-checking bench: a queue-fed driver sends command words, a predictor
// computes the lamp state after each accepted word and a monitor compares it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module dimmer_smoothstep_fade_controller_core_tb;

  // op code with no command behind it
  localparam logic [2:0] OP_NONE = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       on_req;
    logic [7:0] level;
    logic       fault;
    logic       block;
  } cmd_t;

  typedef struct packed {
    logic [6:0] duty;
    logic       out_en;
    logic       fading;
    logic       lamp_on;
    logic [7:0] lamp_level;
    logic       accepted;
    logic       saved_valid;
    logic       saved_on;
    logic [7:0] saved_level;
  } lamp_view_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] op_i = '0;
  logic       on_request_i = 1'b0;
  logic [7:0] level_value_i = '0;
  logic       fault_active_i = 1'b0;
  logic       blocks_turn_on_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] duty_percent_o;
  logic       output_enabled_o, fading_o, lamp_on_o, command_accepted_o;
  logic       saved_valid_o, saved_on_o;
  logic [7:0] lamp_level_o, saved_level_o;

  dimmer_smoothstep_fade_controller_core dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- lamp model
  logic [12:0] steps_cfg [3];
  logic        lm_on, lm_busy, lm_killed, lm_hold_valid, lm_hold_on;
  logic [7:0]  lm_level, lm_hold_level;
  logic [6:0]  lm_duty, lm_start, lm_target;
  logic [12:0] lm_count, lm_total;

  function automatic logic [6:0] duty_of(input logic [7:0] lv);
    return 7'((32'(lv) * 100) / 254);
  endfunction

  function automatic logic [12:0] steps_eff(input int idx);
    return (steps_cfg[idx] == 13'd0) ? 13'd1 : steps_cfg[idx];
  endfunction

  // smoothstep point between two duties
  function automatic logic [6:0] ease(input logic [6:0] from, input logic [6:0] to,
                                      input logic [12:0] step, input logic [12:0] total);
    longint t, t2, s, delta;
    if (total == 13'd0 || step >= total) return to;
    t = (longint'(step) * 65535) / longint'(total);
    t2 = (t * t) / 65535;
    s = (t2 * (3 * 65535 - 2 * t)) / 65535;
    delta = longint'(to) - longint'(from);
    return 7'(longint'(from) + (delta * s) / 65535);
  endfunction

  function automatic void show_at(input logic [12:0] step, input logic flt);
    logic [6:0] d;
    d = ease(lm_start, lm_target, step, lm_total);
    lm_killed = flt;
    if (!flt) lm_duty = d;
  endfunction

  function automatic void apply_now(input logic flt);
    lm_busy = 1'b0;
    lm_killed = flt;
    if (!flt) lm_duty = lm_on ? duty_of(lm_level) : 7'd0;
  endfunction

  function automatic void begin_fade(input logic restart, input logic flt);
    if (flt) begin
      apply_now(1'b1);
      return;
    end
    lm_target = lm_on ? duty_of(lm_level) : 7'd0;
    if (!lm_busy || restart) lm_start = lm_duty;
    if (lm_start == lm_target) begin
      lm_busy = 1'b0;
      show_at(lm_total, 1'b0);
      return;
    end
    lm_count = '0;
    lm_total = lm_on ? steps_eff(restart ? 0 : 2) : steps_eff(1);
    show_at(13'd0, 1'b0);
    lm_busy = 1'b1;
  endfunction

  function automatic lamp_view_t lamp_step(input cmd_t c);
    lamp_view_t v;
    logic acc;
    acc = 1'b1;
    case (c.op)
      dsfc_pkg::OP_SET_ON: begin
        if (c.on_req && c.block) acc = 1'b0;
        else begin
          lm_on = c.on_req;
          if (c.on_req && lm_level <= 8'd1) lm_level = 8'd254;
          begin_fade(1'b1, c.fault);
        end
      end
      dsfc_pkg::OP_SET_LEVEL, dsfc_pkg::OP_CLUSTER: begin
        if (!(c.op == dsfc_pkg::OP_CLUSTER && !lm_on)) begin
          lm_level = c.level;
          if (lm_on) begin_fade(1'b0, c.fault);
        end
      end
      dsfc_pkg::OP_TICK: begin
        if (!lm_busy || c.fault) lm_busy = 1'b0;
        else begin
          lm_count = lm_count + 13'd1;
          if (lm_count >= lm_total) begin
            lm_busy = 1'b0;
            show_at(lm_total, 1'b0);
          end else show_at(lm_count, 1'b0);
        end
      end
      dsfc_pkg::OP_SYNC: begin
        lm_on = c.on_req;
        lm_level = c.level;
        apply_now(c.fault);
      end
      dsfc_pkg::OP_FAULT_OFF: begin
        if (!lm_hold_valid) begin
          lm_hold_on = lm_on;
          lm_hold_level = lm_level;
          lm_hold_valid = 1'b1;
        end
        lm_busy = 1'b0;
        lm_on = 1'b0;
        lm_duty = '0;
        lm_killed = 1'b1;
      end
      dsfc_pkg::OP_RECOVER: begin
        if (lm_hold_valid) begin
          lm_on = lm_hold_on;
          lm_level = lm_hold_level;
          lm_hold_valid = 1'b0;
        end
        apply_now(c.fault);
      end
      default: ;
    endcase
    v = '{lm_duty, !lm_killed, lm_busy, lm_on, lm_level, acc,
          lm_hold_valid, lm_hold_on, lm_hold_level};
    return v;
  endfunction

  initial begin
    steps_cfg[0] = 13'd45; steps_cfg[1] = 13'd35; steps_cfg[2] = 13'd30;
    lm_on = 1'b0; lm_level = 8'd254; lm_duty = '0; lm_busy = 1'b0; lm_count = '0;
    lm_total = '0; lm_start = '0; lm_target = '0; lm_killed = 1'b0;
    lm_hold_valid = 1'b0; lm_hold_on = 1'b0; lm_hold_level = 8'd254;
  end

  // ---------------------------------------------------------------- bookkeeping
  cmd_t       pending_cmds[$];
  lamp_view_t expected_views[$];
  int         errors = 0;
  int         send_idle_pct = 0, recv_stall_pct = 0;
  logic       word_taken = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sample side: prediction on accept, comparison on result, config mirror
  always @(posedge clk_i) begin
    lamp_view_t w, g;
    if (rst_ni && cfg_we_i && cfg_idx_i < 2'd3) steps_cfg[cfg_idx_i] = cfg_data_i;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_views.push_back(lamp_step({op_i, on_request_i, level_value_i,
                                          fault_active_i, blocks_turn_on_i}));
      word_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      g = '{duty_percent_o, output_enabled_o, fading_o, lamp_on_o, lamp_level_o,
            command_accepted_o, saved_valid_o, saved_on_o, saved_level_o};
      if (expected_views.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        w = expected_views.pop_front();
        if (g.duty != w.duty) report("duty_percent", int'(g.duty), int'(w.duty));
        if (g.out_en != w.out_en)
          report("output_enabled", int'(g.out_en), int'(w.out_en));
        if (g.fading != w.fading) report("fading", int'(g.fading), int'(w.fading));
        if (g.lamp_on != w.lamp_on) report("lamp_on", int'(g.lamp_on), int'(w.lamp_on));
        if (g.lamp_level != w.lamp_level)
          report("lamp_level", int'(g.lamp_level), int'(w.lamp_level));
        if (g.accepted != w.accepted)
          report("command_accepted", int'(g.accepted), int'(w.accepted));
        if (g.saved_valid != w.saved_valid)
          report("saved_valid", int'(g.saved_valid), int'(w.saved_valid));
        if (g.saved_on != w.saved_on)
          report("saved_on", int'(g.saved_on), int'(w.saved_on));
        if (g.saved_level != w.saved_level)
          report("saved_level", int'(g.saved_level), int'(w.saved_level));
      end
    end
  end

  // drive side: hold a word until taken, then maybe idle, then the next one
  always @(negedge clk_i) begin
    cmd_t c;
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
          c = pending_cmds.pop_front();
          {op_i, on_request_i, level_value_i, fault_active_i, blocks_turn_on_i} <= c;
          in_valid_i <= 1'b1;
        end else in_valid_i <= 1'b0;
      end
      word_taken = 1'b0;
      out_stall_i <= ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic cmd_t mk(input logic [2:0] op, input logic on_req,
                              input logic [7:0] lv, input logic flt, input logic blk);
    return {op, on_req, lv, flt, blk};
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // a random command word, or none, followed by a run of ticks
  task automatic queue_random_burst();
    int r, n;
    logic flt, blk, req;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    flt = ($urandom_range(0, 9) == 0);
    blk = ($urandom_range(0, 6) == 0);
    req = 1'($urandom);
    if (r < 20) op = dsfc_pkg::OP_SET_ON;
    else if (r < 40) op = dsfc_pkg::OP_SET_LEVEL;
    else if (r < 50) op = dsfc_pkg::OP_CLUSTER;
    else if (r < 62) op = dsfc_pkg::OP_SYNC;
    else if (r < 72) op = dsfc_pkg::OP_FAULT_OFF;
    else if (r < 82) op = dsfc_pkg::OP_RECOVER;
    else op = OP_NONE;
    if (r < 85) pending_cmds.push_back(mk(op, req, pick_level(), flt, blk));
    n = $urandom_range(0, 6);
    repeat (n)
      pending_cmds.push_back(mk(dsfc_pkg::OP_TICK, 1'($urandom), 8'($urandom),
                                ($urandom_range(0, 19) == 0), 1'($urandom)));
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid_i || expected_views.size() != 0)
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_steps(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int sent;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed under the reset step counts
    pending_cmds.push_back(mk(dsfc_pkg::OP_TICK, 1'b0, 8'd0, 1'b0, 1'b0));     // tick idle
    pending_cmds.push_back(mk(dsfc_pkg::OP_CLUSTER, 1'b0, 8'd77, 1'b0, 1'b0)); // while off
    pending_cmds.push_back(mk(dsfc_pkg::OP_SET_ON, 1'b1, 8'd0, 1'b0, 1'b1));   // rejected
    pending_cmds.push_back(mk(dsfc_pkg::OP_SET_ON, 1'b1, 8'd0, 1'b0, 1'b0));
    repeat (3) pending_cmds.push_back(mk(dsfc_pkg::OP_TICK, 1'b1, 8'hFF, 1'b0, 1'b1));
    // change mid-fade
    pending_cmds.push_back(mk(dsfc_pkg::OP_SET_LEVEL, 1'b0, 8'd100, 1'b0, 1'b0));
    // tick under fault
    pending_cmds.push_back(mk(dsfc_pkg::OP_TICK, 1'b0, 8'd0, 1'b1, 1'b0));
    // fault on fade request
    pending_cmds.push_back(mk(dsfc_pkg::OP_SET_LEVEL, 1'b0, 8'd255, 1'b1, 1'b0));
    pending_cmds.push_back(mk(dsfc_pkg::OP_SYNC, 1'b1, 8'd1, 1'b0, 1'b0));
    // level 1 becomes 254
    pending_cmds.push_back(mk(dsfc_pkg::OP_SET_ON, 1'b1, 8'd0, 1'b0, 1'b0));
    // restart while the fade is in progress
    pending_cmds.push_back(mk(dsfc_pkg::OP_SET_ON, 1'b1, 8'd0, 1'b0, 1'b0));
    pending_cmds.push_back(mk(dsfc_pkg::OP_FAULT_OFF, 1'b0, 8'd0, 1'b1, 1'b0));
    // second save ignored
    pending_cmds.push_back(mk(dsfc_pkg::OP_FAULT_OFF, 1'b1, 8'hFF, 1'b1, 1'b1));
    pending_cmds.push_back(mk(dsfc_pkg::OP_RECOVER, 1'b0, 8'd0, 1'b1, 1'b0));
    pending_cmds.push_back(mk(dsfc_pkg::OP_RECOVER, 1'b1, 8'hFF, 1'b0, 1'b1));
    pending_cmds.push_back(mk(OP_NONE, 1'b1, 8'hFF, 1'b1, 1'b1));
    pending_cmds.push_back(mk(dsfc_pkg::OP_SET_LEVEL, 1'b0, 8'd255, 1'b0, 1'b0));
    pending_cmds.push_back(mk(dsfc_pkg::OP_SET_ON, 1'b0, 8'd0, 1'b0, 1'b0));
    repeat (4) pending_cmds.push_back(mk(dsfc_pkg::OP_TICK, 1'b0, 8'd0, 1'b0, 1'b0));
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_steps(dsfc_pkg::REG_STEPS_ON, 13'd0);
          write_steps(dsfc_pkg::REG_STEPS_OFF, 13'd0);
          write_steps(dsfc_pkg::REG_STEPS_LEVEL, 13'd0);
        end
        1: begin
          write_steps(dsfc_pkg::REG_STEPS_ON, 13'd1);
          write_steps(dsfc_pkg::REG_STEPS_OFF, 13'd1);
          write_steps(dsfc_pkg::REG_STEPS_LEVEL, 13'd1);
        end
        2: begin
          write_steps(dsfc_pkg::REG_STEPS_ON, 13'd6553);
          write_steps(dsfc_pkg::REG_STEPS_OFF, 13'd8191);
          write_steps(dsfc_pkg::REG_STEPS_LEVEL, 13'd6553);
        end
        default: begin
          write_steps(dsfc_pkg::REG_STEPS_ON, 13'($urandom_range(1, 8)));
          write_steps(dsfc_pkg::REG_STEPS_OFF, 13'($urandom_range(1, 8)));
          write_steps(dsfc_pkg::REG_STEPS_LEVEL, 13'($urandom_range(1, 8)));
        end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < ((ph == 2) ? 60 : 150)) begin
        queue_random_burst();
        sent = sent + pending_cmds.size();
        while (pending_cmds.size() != 0) @(negedge clk_i);
      end
      wait_drained();
    end

    if (errors == 0) $display("dimmer_smoothstep_fade_controller_core_tb passed");
    else $display("dimmer_smoothstep_fade_controller_core_tb failed");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("dimmer_smoothstep_fade_controller_core_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
src/dsfc_pkg.sv
src/dsfc_div.sv
src/dsfc_ctrl.sv
src/dsfc_dp.sv
src/dimmer_smoothstep_fade_controller_core.sv
tb/sv/dimmer_smoothstep_fade_controller_core_tb.sv
